// File: src/ils_pkg.sv
// shared types, constants and codes for the indexed list store
`default_nettype none

package ils_pkg;

    // list geometry
    localparam int DEPTH   = 64;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 7;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int KEY_W   = 16;
    localparam int PAY_W   = 64;

    // lookup tree: cells are gathered in groups of eight
    localparam int GROUP   = 8;
    localparam int GRP_W   = $clog2(GROUP);
    localparam int NGROUP  = (DEPTH + GROUP - 1) / GROUP;

    // request codes
    typedef enum logic [2:0] {
        ACT_INS_FIRST = 3'd0,
        ACT_INS_AT    = 3'd1,
        ACT_INS_LAST  = 3'd2,
        ACT_DEL_FIRST = 3'd3,
        ACT_DEL_AT    = 3'd4,
        ACT_DEL_LAST  = 3'd5,
        ACT_FIND      = 3'd6,
        ACT_NOP       = 3'd7
    } action_t;

    // result codes
    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_BADPOS   = 3'd3,
        STS_NOTFOUND = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        STATE_IDLE,
        STATE_LOOK,
        STATE_COMMIT
    } state_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic             en;
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] pos;
        logic [CNT_W-1:0] count;
        logic [KEY_W-1:0] cmp_key;
        logic [KEY_W-1:0] new_key;
        logic [PAY_W-1:0] new_payload;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/indexed_list_store.sv
// top level of the indexed list store: request decode, cell chain, lookup tree
// Ordered list of up to DEPTH entries (16-bit key, 64-bit payload) held in a
// chain of cells. Requests arrive on the s_ channel (valid/ready); every
// request gives exactly one result on the m_ channel (valid/ready).
// Actions: insert first/at/last, delete first/at/last, find; action 7 is a
// no-op. Every result carries the entry count after the request.
// Sequence: an item is taken in the idle state; in the lookup state each cell
// compares its entry and a registered tree of eight-cell groups gathers the
// hit and the lowest match; in the commit state the cells shift and the
// result is loaded into the output register. A new item is taken only when
// the sequencer is back in the idle state, after the commit step.
// If the receiver stalls with a result still held, the commit step waits, so
// the list never runs ahead of its results; s_ready stays low meanwhile.
// Reset (aresetn low, synchronous) empties the list and drops any held
// result; entry contents are not cleared and are never read before written.
`default_nettype none

module indexed_list_store (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic [15:0] s_item_key,
    input  wire logic [63:0] s_item_payload,
    input  wire logic [6:0]  s_position,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [15:0]      m_out_key,
    output logic [63:0]      m_out_payload,
    output logic [5:0]       m_found_position,
    output logic [6:0]       m_entry_count
);

    ils_pkg::state_t state_reg;
    ils_pkg::state_t state_next;

    logic [ils_pkg::CNT_W-1:0] count_reg;
    logic [ils_pkg::CNT_W-1:0] count_next;

    // held request
    logic                      req_ins_reg;
    logic                      req_del_reg;
    logic                      req_find_reg;
    logic [ils_pkg::IDX_W-1:0] req_pos_reg;
    ils_pkg::status_t          req_status_reg;
    logic [ils_pkg::KEY_W-1:0] req_key_reg;
    logic [ils_pkg::PAY_W-1:0] req_payload_reg;

    // decoded request
    logic                      dec_ins;
    logic                      dec_del;
    logic                      dec_find;
    logic [ils_pkg::IDX_W-1:0] dec_pos;
    ils_pkg::status_t          dec_status;
    logic                      list_full;
    logic                      list_empty;
    logic [ils_pkg::CMP_W-1:0] pos_ext;
    logic [ils_pkg::CMP_W-1:0] cnt_ext;

    // handshake and sequencing strobes
    logic s_fire;
    logic look_en;
    logic commit;

    // cell chain
    ils_pkg::cell_ctrl_t       ctrl;
    logic [ils_pkg::KEY_W-1:0] cell_key     [ils_pkg::DEPTH];
    logic [ils_pkg::PAY_W-1:0] cell_payload [ils_pkg::DEPTH];
    logic                      cell_match   [ils_pkg::DEPTH];
    logic                      cell_hit     [ils_pkg::DEPTH];

    // lookup tree, first level registered
    logic [ils_pkg::KEY_W-1:0] grp_key_reg  [ils_pkg::NGROUP];
    logic [ils_pkg::KEY_W-1:0] grp_key_next [ils_pkg::NGROUP];
    logic [ils_pkg::PAY_W-1:0] grp_pay_reg  [ils_pkg::NGROUP];
    logic [ils_pkg::PAY_W-1:0] grp_pay_next [ils_pkg::NGROUP];
    logic                      grp_any_reg  [ils_pkg::NGROUP];
    logic                      grp_any_next [ils_pkg::NGROUP];
    logic [ils_pkg::GRP_W-1:0] grp_low_reg  [ils_pkg::NGROUP];
    logic [ils_pkg::GRP_W-1:0] grp_low_next [ils_pkg::NGROUP];

    // second level of the tree
    logic [ils_pkg::KEY_W-1:0] sel_key;
    logic [ils_pkg::PAY_W-1:0] sel_payload;
    logic                      find_any;
    int                        find_idx;

    // output register
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [2:0]       m_status_reg;
    logic [15:0]      m_out_key_reg;
    logic [63:0]      m_out_payload_reg;
    logic [5:0]       m_found_position_reg;
    logic [6:0]       m_entry_count_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ils_pkg::STATE_IDLE: begin
                if (s_valid) state_next = ils_pkg::STATE_LOOK;
            end
            ils_pkg::STATE_LOOK: begin
                state_next = ils_pkg::STATE_COMMIT;
            end
            ils_pkg::STATE_COMMIT: begin
                if (!m_valid_reg || m_ready) state_next = ils_pkg::STATE_IDLE;
            end
            default: begin
                state_next = ils_pkg::STATE_IDLE;
            end
        endcase
    end

    // state outputs, no item taken while in reset
    always_comb begin
        s_ready = 1'b0;
        look_en = 1'b0;
        commit  = 1'b0;
        case (state_reg)
            ils_pkg::STATE_IDLE:   s_ready = aresetn;
            ils_pkg::STATE_LOOK:   look_en = 1'b1;
            ils_pkg::STATE_COMMIT: commit  = !m_valid_reg || m_ready;
            default:               s_ready = 1'b0;
        endcase
    end

    assign s_fire = s_valid && s_ready;

    // request decode against the current count
    always_comb begin
        list_full  = (count_reg == ils_pkg::CNT_W'(ils_pkg::DEPTH));
        list_empty = (count_reg == '0);
        pos_ext    = ils_pkg::CMP_W'(s_position);
        cnt_ext    = ils_pkg::CMP_W'(count_reg);
        dec_ins    = 1'b0;
        dec_del    = 1'b0;
        dec_find   = 1'b0;
        dec_pos    = '0;
        dec_status = ils_pkg::STS_OK;
        case (s_action)
            ils_pkg::ACT_INS_FIRST: begin
                if (list_full) dec_status = ils_pkg::STS_FULL;
                else dec_ins = 1'b1;
            end
            ils_pkg::ACT_INS_AT: begin
                if (list_full) begin
                    dec_status = ils_pkg::STS_FULL;
                end else if (pos_ext > cnt_ext) begin
                    dec_status = ils_pkg::STS_BADPOS;
                end else begin
                    dec_ins = 1'b1;
                    dec_pos = ils_pkg::IDX_W'(s_position);
                end
            end
            ils_pkg::ACT_INS_LAST: begin
                if (list_full) begin
                    dec_status = ils_pkg::STS_FULL;
                end else begin
                    dec_ins = 1'b1;
                    dec_pos = ils_pkg::IDX_W'(count_reg);
                end
            end
            ils_pkg::ACT_DEL_FIRST: begin
                if (list_empty) dec_status = ils_pkg::STS_EMPTY;
                else dec_del = 1'b1;
            end
            ils_pkg::ACT_DEL_AT: begin
                if (list_empty) begin
                    dec_status = ils_pkg::STS_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    dec_status = ils_pkg::STS_BADPOS;
                end else begin
                    dec_del = 1'b1;
                    dec_pos = ils_pkg::IDX_W'(s_position);
                end
            end
            ils_pkg::ACT_DEL_LAST: begin
                if (list_empty) begin
                    dec_status = ils_pkg::STS_EMPTY;
                end else begin
                    dec_del = 1'b1;
                    dec_pos = ils_pkg::IDX_W'(count_reg - 1'b1);
                end
            end
            ils_pkg::ACT_FIND: begin
                dec_find = 1'b1;
            end
            default: begin
                dec_status = ils_pkg::STS_OK;
            end
        endcase
    end

    // control registers: state, count, held request flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ils_pkg::STATE_IDLE;
            count_reg    <= '0;
            req_ins_reg  <= 1'b0;
            req_del_reg  <= 1'b0;
            req_find_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (s_fire) begin
                req_ins_reg  <= dec_ins;
                req_del_reg  <= dec_del;
                req_find_reg <= dec_find;
            end
        end
    end

    // held request payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_pos_reg     <= dec_pos;
            req_status_reg  <= dec_status;
            req_key_reg     <= s_item_key;
            req_payload_reg <= s_item_payload;
        end
    end

    // count update on commit
    always_comb begin
        count_next = count_reg;
        if (commit && req_ins_reg) count_next = count_reg + 1'b1;
        else if (commit && req_del_reg) count_next = count_reg - 1'b1;
    end

    // broadcast to the chain
    always_comb begin
        ctrl.en          = commit;
        ctrl.ins         = req_ins_reg;
        ctrl.del         = req_del_reg;
        ctrl.pos         = req_pos_reg;
        ctrl.count       = count_reg;
        ctrl.cmp_key     = req_key_reg;
        ctrl.new_key     = req_key_reg;
        ctrl.new_payload = req_payload_reg;
    end

    // chain of cells, ends tied back to themselves
    for (genvar i = 0; i < ils_pkg::DEPTH; i++) begin : g_cell
        logic [ils_pkg::KEY_W-1:0] prev_key;
        logic [ils_pkg::PAY_W-1:0] prev_payload;
        logic [ils_pkg::KEY_W-1:0] next_key;
        logic [ils_pkg::PAY_W-1:0] next_payload;

        if (i == 0) begin : g_first
            assign prev_key     = cell_key[i];
            assign prev_payload = cell_payload[i];
        end else begin : g_mid_lo
            assign prev_key     = cell_key[i-1];
            assign prev_payload = cell_payload[i-1];
        end

        if (i == ils_pkg::DEPTH - 1) begin : g_last
            assign next_key     = cell_key[i];
            assign next_payload = cell_payload[i];
        end else begin : g_mid_hi
            assign next_key     = cell_key[i+1];
            assign next_payload = cell_payload[i+1];
        end

        ils_cell u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .idx          (ils_pkg::IDX_W'(i)),
            .prev_key     (prev_key),
            .prev_payload (prev_payload),
            .next_key     (next_key),
            .next_payload (next_payload),
            .key          (cell_key[i]),
            .payload      (cell_payload[i]),
            .match        (cell_match[i]),
            .hit          (cell_hit[i])
        );
    end

    // group level: gather the addressed entry and the lowest match of eight cells
    always_comb begin
        for (int g = 0; g < ils_pkg::NGROUP; g++) begin
            grp_key_next[g] = '0;
            grp_pay_next[g] = '0;
            grp_any_next[g] = 1'b0;
            grp_low_next[g] = '0;
            for (int j = ils_pkg::GROUP - 1; j >= 0; j--) begin
                if (g * ils_pkg::GROUP + j < ils_pkg::DEPTH) begin
                    if (cell_hit[g * ils_pkg::GROUP + j]) begin
                        grp_key_next[g] = grp_key_next[g] | cell_key[g * ils_pkg::GROUP + j];
                        grp_pay_next[g] = grp_pay_next[g]
                                        | cell_payload[g * ils_pkg::GROUP + j];
                    end
                    if (cell_match[g * ils_pkg::GROUP + j]) begin
                        grp_any_next[g] = 1'b1;
                        grp_low_next[g] = ils_pkg::GRP_W'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (look_en) begin
            grp_key_reg <= grp_key_next;
            grp_pay_reg <= grp_pay_next;
            grp_any_reg <= grp_any_next;
            grp_low_reg <= grp_low_next;
        end
    end

    // top level of the tree
    always_comb begin
        sel_key     = '0;
        sel_payload = '0;
        find_any    = 1'b0;
        find_idx    = 0;
        for (int g = ils_pkg::NGROUP - 1; g >= 0; g--) begin
            sel_key     = sel_key | grp_key_reg[g];
            sel_payload = sel_payload | grp_pay_reg[g];
            if (grp_any_reg[g]) begin
                find_any = 1'b1;
                find_idx = g * ils_pkg::GROUP + int'(grp_low_reg[g]);
            end
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_status_reg         <= req_status_reg;
            m_out_key_reg        <= '0;
            m_out_payload_reg    <= '0;
            m_found_position_reg <= '0;
            m_entry_count_reg    <= 7'(count_next);
            if (req_del_reg) begin
                m_out_key_reg     <= sel_key;
                m_out_payload_reg <= sel_payload;
            end
            if (req_find_reg) begin
                if (find_any) begin
                    m_status_reg         <= ils_pkg::STS_OK;
                    m_found_position_reg <= 6'(find_idx);
                end else begin
                    m_status_reg <= ils_pkg::STS_NOTFOUND;
                end
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_out_key        = m_out_key_reg;
    assign m_out_payload    = m_out_payload_reg;
    assign m_found_position = m_found_position_reg;
    assign m_entry_count    = m_entry_count_reg;

`ifndef NO_ASSERTIONS
    // the list never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ils_pkg::CNT_W'(ils_pkg::DEPTH))
        else $error("entry count beyond depth");

    // an accepted item always moves on to the lookup step
    a_accept_look: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == ils_pkg::STATE_LOOK)
        else $error("accepted item did not enter lookup");

    // a commit always leaves a result waiting
    a_commit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid_reg)
        else $error("commit without result");

    // a committed delete takes exactly one entry away
    a_delete_count: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && req_del_reg |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete did not shrink the list by one");

    // an insert and a delete are never requested together
    a_ins_del_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req_ins_reg && req_del_reg))
        else $error("insert and delete both pending");
`endif

endmodule

`default_nettype wire

// File: src/ils_cell.sv
// one list entry: holds a key and payload, shifts to or from its neighbours
`default_nettype none

module ils_cell (
    input  wire logic                     aclk,
    input  wire ils_pkg::cell_ctrl_t      ctrl,
    input  wire logic [ils_pkg::IDX_W-1:0] idx,
    input  wire logic [ils_pkg::KEY_W-1:0] prev_key,
    input  wire logic [ils_pkg::PAY_W-1:0] prev_payload,
    input  wire logic [ils_pkg::KEY_W-1:0] next_key,
    input  wire logic [ils_pkg::PAY_W-1:0] next_payload,
    output logic      [ils_pkg::KEY_W-1:0] key,
    output logic      [ils_pkg::PAY_W-1:0] payload,
    output logic                           match,
    output logic                           hit
);

    logic [ils_pkg::KEY_W-1:0] key_reg;
    logic [ils_pkg::KEY_W-1:0] key_next;
    logic [ils_pkg::PAY_W-1:0] payload_reg;
    logic [ils_pkg::PAY_W-1:0] payload_next;

    // move selection: new item, from lower neighbour, from upper neighbour
    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctrl.en && ctrl.ins) begin
            if (idx == ctrl.pos) begin
                key_next     = ctrl.new_key;
                payload_next = ctrl.new_payload;
            end else if (idx > ctrl.pos) begin
                key_next     = prev_key;
                payload_next = prev_payload;
            end
        end else if (ctrl.en && ctrl.del) begin
            if (idx >= ctrl.pos) begin
                key_next     = next_key;
                payload_next = next_payload;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    // local compare against the searched key and the requested position
    assign match   = (ils_pkg::CNT_W'(idx) < ctrl.count) && (key_reg == ctrl.cmp_key);
    assign hit     = (idx == ctrl.pos);
    assign key     = key_reg;
    assign payload = payload_reg;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench for the indexed list store
`timescale 1ns / 100ps

module testbench;

    // one request as offered on the input channel
    typedef struct packed {
        ils_pkg::action_t action;
        logic [15:0]      key;
        logic [63:0]      payload;
        logic [6:0]       position;
    } list_request_t;

    // one result as returned on the output channel
    typedef struct packed {
        ils_pkg::status_t status;
        logic [15:0]      key;
        logic [63:0]      payload;
        logic [5:0]       found;
        logic [6:0]       count;
    } list_result_t;

    // directed row: request plus an optional hand-written answer
    typedef struct packed {
        list_request_t req;
        logic          typed;
        list_result_t  want;
    } directed_row_t;

    localparam logic [63:0]  ALL_ONES  = 64'hffff_ffff_ffff_ffff;
    localparam list_result_t UNTYPED   = '{ils_pkg::STS_OK, 16'h0, 64'h0, 6'h0, 7'h0};
    localparam int           N_ROWS    = 20;
    localparam int           N_RANDOM  = 1000;
    localparam int           STALL_MAX = 5000;

    // walk through the special cases from an empty list
    localparam directed_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{'{ils_pkg::ACT_DEL_FIRST, 16'h0000, 64'h0, 7'd0}, 1'b1,
          '{ils_pkg::STS_EMPTY, 16'h0, 64'h0, 6'd0, 7'd0}},
        '{'{ils_pkg::ACT_DEL_AT, 16'h0000, 64'h0, 7'd0}, 1'b1,
          '{ils_pkg::STS_EMPTY, 16'h0, 64'h0, 6'd0, 7'd0}},
        '{'{ils_pkg::ACT_DEL_LAST, 16'h0000, 64'h0, 7'd0}, 1'b1,
          '{ils_pkg::STS_EMPTY, 16'h0, 64'h0, 6'd0, 7'd0}},
        '{'{ils_pkg::ACT_FIND, 16'h0000, 64'h0, 7'd0}, 1'b1,
          '{ils_pkg::STS_NOTFOUND, 16'h0, 64'h0, 6'd0, 7'd0}},
        '{'{ils_pkg::ACT_INS_AT, 16'haaaa, 64'h5555, 7'd1}, 1'b1,
          '{ils_pkg::STS_BADPOS, 16'h0, 64'h0, 6'd0, 7'd0}},
        '{'{ils_pkg::ACT_NOP, 16'hffff, ALL_ONES, 7'd127}, 1'b1,
          '{ils_pkg::STS_OK, 16'h0, 64'h0, 6'd0, 7'd0}},
        '{'{ils_pkg::ACT_INS_FIRST, 16'hffff, ALL_ONES, 7'd0}, 1'b1,
          '{ils_pkg::STS_OK, 16'h0, 64'h0, 6'd0, 7'd1}},
        '{'{ils_pkg::ACT_INS_LAST, 16'h0000, 64'h0, 7'd127}, 1'b1,
          '{ils_pkg::STS_OK, 16'h0, 64'h0, 6'd0, 7'd2}},
        '{'{ils_pkg::ACT_INS_AT, 16'h1234, 64'h0123_4567_89ab_cdef, 7'd2}, 1'b0, UNTYPED},
        '{'{ils_pkg::ACT_INS_AT, 16'h1234, 64'hfedc_ba98_7654_3210, 7'd0}, 1'b0, UNTYPED},
        '{'{ils_pkg::ACT_INS_AT, 16'h7777, 64'h1, 7'd127}, 1'b1,
          '{ils_pkg::STS_BADPOS, 16'h0, 64'h0, 6'd0, 7'd4}},
        '{'{ils_pkg::ACT_FIND, 16'hffff, 64'h0, 7'd0}, 1'b1,
          '{ils_pkg::STS_OK, 16'h0, 64'h0, 6'd1, 7'd4}},
        '{'{ils_pkg::ACT_FIND, 16'h1234, 64'h0, 7'd0}, 1'b0, UNTYPED},
        '{'{ils_pkg::ACT_FIND, 16'h5555, 64'h0, 7'd0}, 1'b1,
          '{ils_pkg::STS_NOTFOUND, 16'h0, 64'h0, 6'd0, 7'd4}},
        '{'{ils_pkg::ACT_DEL_AT, 16'h0000, 64'h0, 7'd4}, 1'b1,
          '{ils_pkg::STS_BADPOS, 16'h0, 64'h0, 6'd0, 7'd4}},
        '{'{ils_pkg::ACT_DEL_AT, 16'h0000, 64'h0, 7'd127}, 1'b1,
          '{ils_pkg::STS_BADPOS, 16'h0, 64'h0, 6'd0, 7'd4}},
        '{'{ils_pkg::ACT_DEL_AT, 16'h0000, 64'h0, 7'd2}, 1'b1,
          '{ils_pkg::STS_OK, 16'h0000, 64'h0, 6'd0, 7'd3}},
        '{'{ils_pkg::ACT_DEL_LAST, 16'h0000, 64'h0, 7'd0}, 1'b0, UNTYPED},
        '{'{ils_pkg::ACT_DEL_FIRST, 16'h0000, 64'h0, 7'd0}, 1'b0, UNTYPED},
        '{'{ils_pkg::ACT_DEL_FIRST, 16'h0000, 64'h0, 7'd0}, 1'b1,
          '{ils_pkg::STS_OK, 16'hffff, ALL_ONES, 6'd0, 7'd0}}
    };

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action       = 3'd0;
    logic [15:0] s_item_key     = 16'h0;
    logic [63:0] s_item_payload = 64'h0;
    logic [6:0]  s_position     = 7'd0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_out_key;
    logic [63:0] m_out_payload;
    logic [5:0]  m_found_position;
    logic [6:0]  m_entry_count;

    // shadow copy of the list
    logic [15:0] list_keys     [ils_pkg::DEPTH];
    logic [63:0] list_payloads [ils_pkg::DEPTH];
    int          list_len;

    list_result_t pending_results [$];
    int           mismatch_count     = 0;
    int           sender_idle_pct    = 0;
    int           receiver_stall_pct = 0;
    int           quiet_cycles       = 0;

    indexed_list_store dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_item_key       (s_item_key),
        .s_item_payload   (s_item_payload),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_out_key        (m_out_key),
        .m_out_payload    (m_out_payload),
        .m_found_position (m_found_position),
        .m_entry_count    (m_entry_count)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // apply one request to the shadow list and return its result
    function automatic list_result_t apply_request(list_request_t req);
        list_result_t res;
        int           slot;
        res = UNTYPED;
        slot = 0;
        case (req.action)
            ils_pkg::ACT_INS_FIRST, ils_pkg::ACT_INS_AT, ils_pkg::ACT_INS_LAST: begin
                if (req.action == ils_pkg::ACT_INS_AT) slot = int'(req.position);
                if (req.action == ils_pkg::ACT_INS_LAST) slot = list_len;
                if (list_len >= ils_pkg::DEPTH) begin
                    res.status = ils_pkg::STS_FULL;
                end else if (slot > list_len) begin
                    res.status = ils_pkg::STS_BADPOS;
                end else begin
                    for (int i = list_len; i > slot; i--) begin
                        list_keys[i]     = list_keys[i-1];
                        list_payloads[i] = list_payloads[i-1];
                    end
                    list_keys[slot]     = req.key;
                    list_payloads[slot] = req.payload;
                    list_len++;
                end
            end
            ils_pkg::ACT_DEL_FIRST, ils_pkg::ACT_DEL_AT, ils_pkg::ACT_DEL_LAST: begin
                if (req.action == ils_pkg::ACT_DEL_AT) slot = int'(req.position);
                if (req.action == ils_pkg::ACT_DEL_LAST) slot = list_len - 1;
                if (list_len == 0) begin
                    res.status = ils_pkg::STS_EMPTY;
                end else if (slot >= list_len) begin
                    res.status = ils_pkg::STS_BADPOS;
                end else begin
                    res.key     = list_keys[slot];
                    res.payload = list_payloads[slot];
                    for (int i = slot; i + 1 < list_len; i++) begin
                        list_keys[i]     = list_keys[i+1];
                        list_payloads[i] = list_payloads[i+1];
                    end
                    list_len--;
                end
            end
            ils_pkg::ACT_FIND: begin
                res.status = ils_pkg::STS_NOTFOUND;
                for (int i = 0; i < list_len; i++) begin
                    if (list_keys[i] == req.key) begin
                        res.status = ils_pkg::STS_OK;
                        res.found  = i[5:0];
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.count = list_len[6:0];
        return res;
    endfunction

    // random request; mode 0 grows the list, 2 shrinks it, others mix
    function automatic list_request_t random_request(int mode);
        list_request_t req;
        int            roll;
        int            grow_pct;
        int            shrink_pct;
        grow_pct   = (mode == 0) ? 80 : (mode == 2) ? 12 : 42;
        shrink_pct = (mode == 2) ? 80 : (mode == 0) ? 12 : 42;
        roll       = $urandom_range(99);
        req.payload  = {$urandom, $urandom};
        req.position = 7'($urandom_range(127));
        if ($urandom_range(3) == 0) begin
            req.key = 16'($urandom_range(7));
        end else begin
            req.key = 16'($urandom_range(16'hffff));
        end
        if (roll < grow_pct) begin
            case ($urandom_range(2))
                0:       req.action = ils_pkg::ACT_INS_FIRST;
                1:       req.action = ils_pkg::ACT_INS_AT;
                default: req.action = ils_pkg::ACT_INS_LAST;
            endcase
            if ($urandom_range(99) < 85) req.position = 7'($urandom_range(list_len));
        end else if (roll < grow_pct + shrink_pct) begin
            case ($urandom_range(2))
                0:       req.action = ils_pkg::ACT_DEL_FIRST;
                1:       req.action = ils_pkg::ACT_DEL_AT;
                default: req.action = ils_pkg::ACT_DEL_LAST;
            endcase
            if (list_len > 0 && $urandom_range(99) < 85)
                req.position = 7'($urandom_range(list_len - 1));
        end else if (roll < 98) begin
            req.action = ils_pkg::ACT_FIND;
            // half the time, when the list is not empty, look up a key that is present
            if (list_len > 0 && $urandom_range(1) == 0)
                req.key = list_keys[$urandom_range(list_len - 1)];
        end else begin
            req.action = ils_pkg::ACT_NOP;
        end
        return req;
    endfunction

    // offer one item, wait for it to be taken, then record its expectation
    task automatic run_item(list_request_t req, logic typed, list_result_t want);
        list_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= req.action;
        s_item_key     <= req.key;
        s_item_payload <= req.payload;
        s_position     <= req.position;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_request(req);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // stimulus
    initial begin
        list_len = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part with no idling
        for (int r = 0; r < N_ROWS; r++)
            run_item(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // random part in idling phases
        for (int n = 0; n < N_RANDOM; n++) begin
            sender_idle_pct    = (n >= 250 && n < 500) ? 82 : (n >= 750) ? 10 : 0;
            receiver_stall_pct = (n >= 500 && n < 750) ? 82 : (n >= 750) ? 10 : 0;
            run_item(random_request((n / 100) % 4), 1'b0, UNTYPED);
        end
        s_valid <= 1'b0;

        // drain, then allow for the pipeline
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // result checking, receiver stalls and watchdog
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: status %0d key %0h payload %0h pos %0d count %0d",
                         $time, m_status, m_out_key, m_out_payload, m_found_position,
                         m_entry_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("status", 64'(want.status), 64'(m_status));
                compare_field("out_key", 64'(want.key), 64'(m_out_key));
                compare_field("out_payload", want.payload, m_out_payload);
                compare_field("found_position", 64'(want.found), 64'(m_found_position));
                compare_field("entry_count", 64'(want.count), 64'(m_entry_count));
            end
        end
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);

        // watchdog on cycles with no item moving on either channel
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
